/* sv/sut_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sut_pkg: shared types for the sorted unique result table
// Word formats, table entry layout, command and status codes.
// ----------------------------------------------------------------------------
package sut_pkg;

  localparam int POS_W = 7;
  localparam int KEY_W = 33;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } sut_cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_NO_DATA   = 3'd4
  } sut_status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  read_index;
    logic        is_name;
    logic [31:0] dict_offset;
    logic [7:0]  match_length;
    logic [7:0]  key_len;
    logic [7:0]  inflection_length;
    logic [23:0] text_offset;
  } sut_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
    logic             out_is_name;
    logic [31:0]      out_dict_offset;
    logic [7:0]       out_match_length;
    logic [7:0]       out_key_len;
    logic [7:0]       out_inflection_length;
    logic [23:0]      out_text_offset;
  } sut_out_t;

  // Stored entry: sort key on top, record info below
  typedef struct packed {
    logic        is_name;
    logic [31:0] dict_offset;
    logic [23:0] text_offset;
    logic [7:0]  inflection_length;
    logic [7:0]  key_len;
    logic [7:0]  match_length;
  } sut_entry_t;

  localparam int ENTRY_W = $bits(sut_entry_t);

endpackage
`default_nettype wire

/* sv/sut_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sut_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sut_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/sut_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sut_seq: command sequencer for the sorted unique result table
// Binary search on the {is_name, dict_offset} key, entry shift and reads.
// ----------------------------------------------------------------------------
module sut_seq #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sut_pkg::sut_in_t             in_word_i,
  output logic                              res_valid_o,
  input  wire logic                         res_free_i,
  output sut_pkg::sut_out_t                 res_word_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic [sut_pkg::ENTRY_W-1:0]       mem_wdata_o,
  output logic                              mem_re_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  wire logic [sut_pkg::ENTRY_W-1:0]  mem_rdata_i
);

  import sut_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_READ,
    S_RDWAIT,
    S_DONE
  } state_e;

  function automatic sut_out_t mk_res(sut_status_e st, logic [POS_W-1:0] pos,
                                      logic [POS_W-1:0] cnt);
    sut_out_t r;
    r             = '0;
    r.status      = st;
    r.position    = pos;
    r.entry_count = cnt;
    return r;
  endfunction

  state_e     state_q;
  logic [5:0] idx_q;
  sut_entry_t ent_q;
  logic [CW-1:0] count_q, lo_q, hi_q, ptr_q;
  logic       found_q, pend_q;
  logic [AW-1:0] wa_q;
  sut_out_t   res_q;

  logic [CW-1:0]    mid, ptr_dec;
  sut_entry_t       rd_ent;
  logic [KEY_W-1:0] rd_key, new_key;
  logic [XW-1:0]    count_x, lo_x, idx_x, cnt_inc_x;
  logic             idx_ok, full, accept;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_dec   = ptr_q - CW'(1);
  assign rd_ent    = sut_entry_t'(mem_rdata_i);
  assign rd_key    = {rd_ent.is_name, rd_ent.dict_offset};
  assign new_key   = {ent_q.is_name, ent_q.dict_offset};
  assign count_x   = XW'(count_q);
  assign lo_x      = XW'(lo_q);
  assign idx_x     = XW'(idx_q);
  assign cnt_inc_x = count_x + XW'(1);
  assign idx_ok    = idx_x < count_x;
  assign full      = count_q == CW'(DEPTH);
  assign accept    = in_valid_i && (state_q == S_IDLE);

  assign in_stall_o  = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_word_o  = res_q;

  // memory port control
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;
    unique case (state_q)
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = mid[AW-1:0];
        end
      end
      S_SHIFT: begin
        if (ptr_q > lo_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_dec[AW-1:0];
        end
        if (pend_q) begin
          mem_we_o = 1'b1;
        end else if (ptr_q == lo_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = lo_q[AW-1:0];
          mem_wdata_o = ent_q;
        end
      end
      S_READ: begin
        mem_re_o    = idx_ok;
        mem_raddr_o = idx_x[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      ent_q   <= '0;
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      wa_q    <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q <= in_word_i.read_index;
            ent_q <= '{is_name:           in_word_i.is_name,
                       dict_offset:       in_word_i.dict_offset,
                       text_offset:       in_word_i.text_offset,
                       inflection_length: in_word_i.inflection_length,
                       key_len:           in_word_i.key_len,
                       match_length:      in_word_i.match_length};
            unique case (in_word_i.command)
              CMD_INSERT: begin
                lo_q    <= '0;
                hi_q    <= count_q;
                found_q <= 1'b0;
                state_q <= S_PROBE;
              end
              CMD_READ: begin
                state_q <= S_READ;
              end
              CMD_CLEAR: begin
                count_q <= '0;
                res_q   <= mk_res(ST_NO_DATA, '0, '0);
                state_q <= S_DONE;
              end
              default: begin
                res_q   <= mk_res(ST_NO_DATA, '0, count_x[POS_W-1:0]);
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_PROBE: begin
          if (lo_q < hi_q) begin
            state_q <= S_CMP;
          end else if (found_q) begin
            res_q   <= mk_res(ST_DUPLICATE, lo_x[POS_W-1:0], count_x[POS_W-1:0]);
            state_q <= S_DONE;
          end else if (full) begin
            res_q   <= mk_res(ST_FULL, lo_x[POS_W-1:0], count_x[POS_W-1:0]);
            state_q <= S_DONE;
          end else begin
            ptr_q   <= count_q;
            pend_q  <= 1'b0;
            state_q <= S_SHIFT;
          end
        end
        S_CMP: begin
          // lower-bound step; the probe that hits the key always happens
          if (rd_key < new_key) begin
            lo_q <= mid + CW'(1);
          end else begin
            hi_q <= mid;
          end
          if (rd_key == new_key) begin
            found_q <= 1'b1;
          end
          state_q <= S_PROBE;
        end
        S_SHIFT: begin
          // read entry ptr-1 now, its data lands at ptr next cycle
          if (ptr_q > lo_q) begin
            ptr_q  <= ptr_dec;
            pend_q <= 1'b1;
            wa_q   <= ptr_q[AW-1:0];
          end else begin
            pend_q <= 1'b0;
          end
          if (!pend_q && (ptr_q == lo_q)) begin
            count_q <= count_q + CW'(1);
            res_q   <= mk_res(ST_INSERTED, lo_x[POS_W-1:0], cnt_inc_x[POS_W-1:0]);
            state_q <= S_DONE;
          end
        end
        S_READ: begin
          if (idx_ok) begin
            state_q <= S_RDWAIT;
          end else begin
            res_q   <= mk_res(ST_NO_DATA, idx_x[POS_W-1:0], count_x[POS_W-1:0]);
            state_q <= S_DONE;
          end
        end
        S_RDWAIT: begin
          res_q <= '{status:                ST_READ_OK,
                     position:              idx_x[POS_W-1:0],
                     entry_count:           count_x[POS_W-1:0],
                     out_is_name:           rd_ent.is_name,
                     out_dict_offset:       rd_ent.dict_offset,
                     out_match_length:      rd_ent.match_length,
                     out_key_len:           rd_ent.key_len,
                     out_inflection_length: rd_ent.inflection_length,
                     out_text_offset:       rd_ent.text_offset};
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/sorted_unique_result_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_result_table: sorted match record table with duplicate reject
// Keeps records ordered by {is_name, dict_offset}; insert, read, clear.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+-----------------
//  in      | input     | in_valid_i / in_stall_o  | sut_in_t
//  out     | output    | out_valid_o / out_stall_i| sut_out_t
//
// Insert: binary search with a table RAM read and a key compare per probe,
// then a shift of the entries above the slot, one entry per cycle. Read goes
// through S_READ and S_RDWAIT; clear and unused commands go to S_DONE.
// One command at a time: in_stall_o is high from accept until the result is
// handed to the output register. A stalled output register holds one result
// while the next command is taken. Reset empties the table at once.
//
module sorted_unique_result_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sut_pkg::sut_in_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sut_pkg::sut_out_t      out_word_o
);

  import sut_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic               res_valid, res_free;
  sut_out_t           res_word;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic     out_valid_q;
  sut_out_t out_word_q;

  sut_seq #(
    .DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_free_i  (res_free),
    .res_word_o  (res_word),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sut_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while sequencer not busy afterwards");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (TABLE_DEPTH < 128)) |-> (out_word_o.entry_count <= TABLE_DEPTH))
    else $error("entry count above table depth");

  a_pos_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (TABLE_DEPTH < 128) &&
     (out_word_o.status == ST_INSERTED || out_word_o.status == ST_DUPLICATE ||
      out_word_o.status == ST_READ_OK))
    |-> (out_word_o.position < out_word_o.entry_count))
    else $error("reported position outside held entries");
`endif

endmodule
`default_nettype wire
